[src/i2cm_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants for the i2c master byte engine
// no dependencies; used by the channel interfaces and the top level
package i2cm_pkg;

  localparam logic [15:0] PHASE_WAIT_RESET = 16'd190;

  // command codes carried in the opcode field
  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
    logic       scl_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_data;
    logic       ack_bit;
  } out_item_t;

endpackage

[src/i2cm_if.sv]
`timescale 1ns / 1ps
// valid/ready channel interfaces for the i2c master byte engine
// depends on i2cm_pkg for the payload types
interface i2cm_in_if;
  import i2cm_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface i2cm_out_if;
  import i2cm_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface i2cm_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[src/i2c_master_byte_engine.sv]
`timescale 1ns / 1ps
// i2c master byte engine: one transaction in per clock tick, one result out
// the result of a tick transaction is registered and shown in the cycle after it is taken
// throughput: one transaction per cycle, set by the single registered update of
// the phase sequencer; a new tick enters when the output register is empty or read
// reset (rst_n low, synchronous): idle, both pins released, wait 190 ticks
// depends on i2cm_pkg and the channel interfaces in i2cm_if.sv
module i2c_master_byte_engine (
  input  logic clk,
  input  logic rst_n,
  i2cm_in_if.sink    in_chan,
  i2cm_out_if.source out_chan,
  i2cm_cfg_if.sink   cfg_chan
);
  import i2cm_pkg::*;

  typedef enum logic [19:0] {
    PH_IDLE = 20'h00001,
    ST_SDA  = 20'h00002,
    ST_SCL  = 20'h00004,
    SP_SDA  = 20'h00008,
    SP_SCL  = 20'h00010,
    SP_REL  = 20'h00020,
    WR_DATA = 20'h00040,
    WR_SCLH = 20'h00080,
    WR_SCLL = 20'h00100,
    WR_AREL = 20'h00200,
    WR_AH   = 20'h00400,
    WR_AL   = 20'h00800,
    WR_END  = 20'h01000,
    RD_REL  = 20'h02000,
    RD_SCLH = 20'h04000,
    RD_SCLL = 20'h08000,
    RD_ACK  = 20'h10000,
    RD_AH   = 20'h20000,
    RD_AL   = 20'h40000,
    RD_END  = 20'h80000
  } phase_t;

  phase_t      phase_r, phase_nxt, act_ph;
  logic [3:0]  bit_r, bit_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [15:0] wait_r, wait_nxt, wait_load;
  logic        scl_r, scl_nxt, sda_r, sda_nxt;
  logic [7:0]  rx_r, rx_nxt;
  logic        ack_r, ack_nxt;
  logic        stretch_r, stretch_nxt;
  logic        ackreq_r, ackreq_nxt;
  logic [15:0] phase_wait_r;
  logic        do_act, done, release_scl;

  logic      out_valid_r;
  out_item_t out_data_r;
  logic      in_acc;
  in_item_t  it;

  assign it              = in_chan.data;
  assign in_chan.ready   = !out_valid_r || out_chan.ready;
  assign in_acc          = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready  = 1'b1;
  assign out_chan.valid  = out_valid_r;
  assign out_chan.data   = out_data_r;
  // a zero wait acts like one tick
  assign wait_load       = (phase_wait_r == 16'd0) ? 16'd1 : phase_wait_r;

  always_comb begin
    phase_nxt   = phase_r;
    bit_nxt     = bit_r;
    shift_nxt   = shift_r;
    wait_nxt    = wait_r;
    scl_nxt     = scl_r;
    sda_nxt     = sda_r;
    rx_nxt      = rx_r;
    ack_nxt     = ack_r;
    stretch_nxt = stretch_r;
    ackreq_nxt  = ackreq_r;
    do_act      = 1'b0;
    act_ph      = PH_IDLE;
    done        = 1'b0;
    release_scl = 1'b0;

    if (phase_r == PH_IDLE) begin
      bit_nxt = 4'd0;
      case (it.opcode)
        OP_START: begin
          do_act = 1'b1;
          act_ph = ST_SDA;
        end
        OP_STOP: begin
          do_act = 1'b1;
          act_ph = SP_SDA;
        end
        OP_WRITE: begin
          shift_nxt = it.tx_byte;
          do_act    = 1'b1;
          act_ph    = WR_DATA;
        end
        OP_READ: begin
          shift_nxt  = 8'd0;
          ackreq_nxt = it.send_ack;
          do_act     = 1'b1;
          act_ph     = RD_REL;
        end
        default: ;
      endcase
    end else if (stretch_r) begin
      if (it.scl_in) begin
        stretch_nxt = 1'b0;
        wait_nxt    = wait_load;
      end
    end else if (wait_r > 16'd1) begin
      wait_nxt = wait_r - 16'd1;
    end else begin
      do_act = 1'b1;
      case (phase_r)
        ST_SDA:  act_ph = ST_SCL;
        SP_SDA:  act_ph = SP_SCL;
        SP_SCL:  act_ph = SP_REL;
        WR_DATA: act_ph = WR_SCLH;
        WR_SCLH: act_ph = WR_SCLL;
        WR_SCLL: act_ph = (bit_r < 4'd8) ? WR_DATA : WR_AREL;
        WR_AREL: act_ph = WR_AH;
        WR_AH:   act_ph = WR_AL;
        WR_AL:   act_ph = WR_END;
        RD_REL:  act_ph = RD_SCLH;
        RD_SCLH: act_ph = RD_SCLL;
        RD_SCLL: act_ph = (bit_r < 4'd8) ? RD_SCLH : RD_ACK;
        RD_ACK:  act_ph = RD_AH;
        RD_AH:   act_ph = RD_AL;
        RD_AL:   act_ph = RD_END;
        default: begin
          // last phase of a command: finish
          do_act = 1'b0;
          done   = 1'b1;
          if (phase_r == RD_END) rx_nxt = shift_r;
          phase_nxt = PH_IDLE;
          wait_nxt  = 16'd0;
        end
      endcase
    end

    if (do_act) begin
      case (act_ph)
        ST_SDA, SP_SDA, WR_END, RD_END: sda_nxt = 1'b0;
        ST_SCL, RD_AL: scl_nxt = 1'b0;
        SP_SCL, WR_SCLH, WR_AH, RD_SCLH, RD_AH: begin
          scl_nxt     = 1'b1;
          release_scl = 1'b1;
        end
        SP_REL, WR_AREL, RD_REL: sda_nxt = 1'b1;
        WR_DATA: sda_nxt = shift_nxt[7];
        WR_SCLL: begin
          scl_nxt   = 1'b0;
          shift_nxt = {shift_nxt[6:0], 1'b0};
          bit_nxt   = bit_nxt + 4'd1;
        end
        WR_AL: begin
          ack_nxt = it.sda_in;
          scl_nxt = 1'b0;
        end
        RD_SCLL: begin
          shift_nxt = {shift_nxt[6:0], it.sda_in};
          scl_nxt   = 1'b0;
          bit_nxt   = bit_nxt + 4'd1;
        end
        RD_ACK: sda_nxt = !ackreq_nxt;
        default: ;
      endcase
      phase_nxt = act_ph;
      // after releasing scl, hold until the line reads high
      if (release_scl) begin
        stretch_nxt = 1'b1;
        wait_nxt    = 16'd0;
      end else begin
        stretch_nxt = 1'b0;
        wait_nxt    = wait_load;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      bit_r        <= 4'd0;
      shift_r      <= 8'd0;
      wait_r       <= 16'd0;
      scl_r        <= 1'b1;
      sda_r        <= 1'b1;
      rx_r         <= 8'd0;
      ack_r        <= 1'b0;
      stretch_r    <= 1'b0;
      ackreq_r     <= 1'b0;
      phase_wait_r <= PHASE_WAIT_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_chan.valid) phase_wait_r <= cfg_chan.data;
      if (in_acc) begin
        phase_r     <= phase_nxt;
        bit_r       <= bit_nxt;
        shift_r     <= shift_nxt;
        wait_r      <= wait_nxt;
        scl_r       <= scl_nxt;
        sda_r       <= sda_nxt;
        rx_r        <= rx_nxt;
        ack_r       <= ack_nxt;
        stretch_r   <= stretch_nxt;
        ackreq_r    <= ackreq_nxt;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r.scl_out  <= scl_nxt;
      out_data_r.sda_out  <= sda_nxt;
      out_data_r.busy_res <= (phase_nxt != PH_IDLE);
      out_data_r.done_res <= done;
      out_data_r.rx_data  <= rx_nxt;
      out_data_r.ack_bit  <= ack_nxt;
    end
  end

  a_idle_no_stretch: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> !stretch_r)
    else $error("stretch flag set while idle");

  a_stretch_scl_released: assert property (@(posedge clk) disable iff (!rst_n)
    stretch_r |-> (scl_r && wait_r == 16'd0))
    else $error("clock stretch wait without scl released");

  a_wait_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_IDLE && !stretch_r) |-> (wait_r != 16'd0))
    else $error("phase wait counter empty mid-command");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("accepted tick produced no result");

  a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && done) |=> (phase_r == PH_IDLE && out_data_r.done_res))
    else $error("finishing tick left engine busy");

endmodule

[dv/i2c_master_byte_engine_tb.sv]
`timescale 1ns / 1ps
// self-checking testbench for i2c_master_byte_engine: a directed table, then random ticks
// every result is compared with a typed row's want, else with a cycle model of the bit engine kept in this file
// depends on i2cm_pkg, the channel interfaces in i2cm_if.sv and the engine itself
module i2c_master_byte_engine_tb;
  import i2cm_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int LONG_WAIT_TICKS = 16;
  localparam int MAX_REPORTS = 10;
  localparam int SCRIPT_LEN = 17;
  localparam logic [2:0] OP_UNKNOWN_LO = OP_READ + 3'd1;
  localparam logic [2:0] OP_UNKNOWN_HI = 3'd7;

  typedef enum logic [4:0] {
    IDLE_PH, START_SDA, START_SCL, STOP_SDA, STOP_SCL, STOP_REL,
    WR_BIT, WR_SCL_HI, WR_SCL_LO, WR_ACK_REL, WR_ACK_HI, WR_ACK_LO, WR_FIN,
    RD_RELEASE, RD_SCL_HI, RD_SCL_LO, RD_ACK_DRV, RD_ACK_HI, RD_ACK_LO, RD_FIN,
    DONE_PH
  } bus_phase_t;

  typedef struct packed {
    in_item_t    stim;
    logic        typed;
    out_item_t   want;
    logic        drain;
    logic        set_wait;
    logic [15:0] wait_val;
  } script_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  i2cm_in_if  in_if ();
  i2cm_out_if out_if ();
  i2cm_cfg_if cfg_if ();

  i2c_master_byte_engine i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // engine model state
  bus_phase_t  eng_phase = IDLE_PH;
  logic [3:0]  eng_bits = '0;
  logic [7:0]  eng_shift = '0;
  logic [15:0] eng_wait = '0;
  logic        eng_scl = 1'b1;
  logic        eng_sda = 1'b1;
  logic [7:0]  eng_rx = '0;
  logic        eng_ack = 1'b0;
  logic        eng_stretch = 1'b0;
  logic        eng_ack_req = 1'b0;
  logic [15:0] eng_wait_ticks = PHASE_WAIT_RESET;

  out_item_t   pin_results_q[$];
  script_row_t script [SCRIPT_LEN];
  logic        cur_typed = 1'b0;
  out_item_t   cur_want = '0;
  int          send_idle = 14;
  int          recv_idle = 81;
  int          mismatches = 0;
  int          stall_cycles = 0;

  // a wait of zero behaves like one
  function automatic void load_wait();
    eng_wait = (eng_wait_ticks == 16'd0) ? 16'd1 : eng_wait_ticks;
  endfunction

  function automatic void enter_phase(input bus_phase_t ph, input logic sda);
    logic release_scl;
    release_scl = 1'b0;
    case (ph)
      START_SDA, STOP_SDA, WR_FIN, RD_FIN: eng_sda = 1'b0;
      START_SCL, RD_ACK_LO: eng_scl = 1'b0;
      STOP_SCL, WR_SCL_HI, WR_ACK_HI, RD_SCL_HI, RD_ACK_HI: begin
        eng_scl = 1'b1;
        release_scl = 1'b1;
      end
      STOP_REL, WR_ACK_REL, RD_RELEASE: eng_sda = 1'b1;
      WR_BIT: eng_sda = eng_shift[7];
      WR_SCL_LO: begin
        eng_scl = 1'b0;
        eng_shift = {eng_shift[6:0], 1'b0};
        eng_bits = eng_bits + 4'd1;
      end
      WR_ACK_LO: begin
        eng_ack = sda;
        eng_scl = 1'b0;
      end
      RD_SCL_LO: begin
        eng_shift = {eng_shift[6:0], sda};
        eng_scl = 1'b0;
        eng_bits = eng_bits + 4'd1;
      end
      RD_ACK_DRV: eng_sda = !eng_ack_req;
      default: ;
    endcase
    eng_phase = ph;
    // after releasing scl the countdown only starts once the line reads high
    if (release_scl) begin
      eng_stretch = 1'b1;
      eng_wait = '0;
    end else begin
      eng_stretch = 1'b0;
      load_wait();
    end
  endfunction

  function automatic bus_phase_t follow_phase(input bus_phase_t ph);
    case (ph)
      START_SDA: return START_SCL;
      STOP_SDA: return STOP_SCL;
      STOP_SCL: return STOP_REL;
      WR_BIT: return WR_SCL_HI;
      WR_SCL_HI: return WR_SCL_LO;
      WR_SCL_LO: return (eng_bits < 4'd8) ? WR_BIT : WR_ACK_REL;
      WR_ACK_REL: return WR_ACK_HI;
      WR_ACK_HI: return WR_ACK_LO;
      WR_ACK_LO: return WR_FIN;
      RD_RELEASE: return RD_SCL_HI;
      RD_SCL_HI: return RD_SCL_LO;
      RD_SCL_LO: return (eng_bits < 4'd8) ? RD_SCL_HI : RD_ACK_DRV;
      RD_ACK_DRV: return RD_ACK_HI;
      RD_ACK_HI: return RD_ACK_LO;
      RD_ACK_LO: return RD_FIN;
      default: return DONE_PH;
    endcase
  endfunction

  function automatic out_item_t engine_tick(input in_item_t it);
    out_item_t  res;
    bus_phase_t nx;
    logic       done;
    done = 1'b0;
    if (eng_phase == IDLE_PH) begin
      eng_bits = '0;
      case (it.opcode)
        OP_START: enter_phase(START_SDA, it.sda_in);
        OP_STOP: enter_phase(STOP_SDA, it.sda_in);
        OP_WRITE: begin
          eng_shift = it.tx_byte;
          enter_phase(WR_BIT, it.sda_in);
        end
        OP_READ: begin
          eng_shift = '0;
          eng_ack_req = it.send_ack;
          enter_phase(RD_RELEASE, it.sda_in);
        end
        default: ;
      endcase
    end else if (eng_stretch) begin
      if (it.scl_in) begin
        eng_stretch = 1'b0;
        load_wait();
      end
    end else if (eng_wait > 16'd1) begin
      eng_wait = eng_wait - 16'd1;
    end else begin
      nx = follow_phase(eng_phase);
      if (nx == DONE_PH) begin
        if (eng_phase == RD_FIN) eng_rx = eng_shift;
        eng_phase = IDLE_PH;
        eng_wait = '0;
        done = 1'b1;
      end else begin
        enter_phase(nx, it.sda_in);
      end
    end
    res.scl_out = eng_scl;
    res.sda_out = eng_sda;
    res.busy_res = (eng_phase != IDLE_PH);
    res.done_res = done;
    res.rx_data = eng_rx;
    res.ack_bit = eng_ack;
    return res;
  endfunction

  always @(negedge clk) begin
    out_if.ready <= ($urandom_range(99) >= recv_idle);
  end

  // result check, model update on accepted ticks, and watchdog
  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (out_if.valid && out_if.ready) begin
      got = out_if.data;
      if (pin_results_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: scl %b sda %b busy %b done %b rx %h ack %b",
                   got.scl_out, got.sda_out, got.busy_res, got.done_res, got.rx_data,
                   got.ack_bit);
      end else begin
        want = pin_results_q.pop_front();
        if (got.scl_out !== want.scl_out || got.sda_out !== want.sda_out ||
            got.busy_res !== want.busy_res || got.done_res !== want.done_res ||
            got.rx_data !== want.rx_data || got.ack_bit !== want.ack_bit) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: expected scl %b sda %b busy %b done %b rx %h ack %b, %s",
                     want.scl_out, want.sda_out, want.busy_res, want.done_res,
                     want.rx_data, want.ack_bit,
                     $sformatf("got scl %b sda %b busy %b done %b rx %h ack %b",
                               got.scl_out, got.sda_out, got.busy_res, got.done_res,
                               got.rx_data, got.ack_bit));
        end
      end
    end
    if (in_if.valid && in_if.ready) begin
      want = engine_tick(in_if.data);
      pin_results_q.push_back(cur_typed ? cur_want : want);
    end
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic send_tick(input in_item_t it, input logic typed, input out_item_t want);
    while ($urandom_range(99) < send_idle) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data <= it;
    cur_typed = typed;
    cur_want = want;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    do @(negedge clk); while (pin_results_q.size() != 0);
  endtask

  task automatic write_wait_ticks(input logic [15:0] ticks);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= ticks;
    do @(posedge clk); while (!cfg_if.ready);
    eng_wait_ticks = ticks;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic in_item_t random_tick();
    in_item_t it;
    int       pick;
    it.tx_byte = 8'($urandom);
    it.send_ack = 1'($urandom);
    it.sda_in = 1'($urandom);
    it.scl_in = ($urandom_range(3) != 0);
    pick = $urandom_range(99);
    // mostly real commands when idle, anything at all while busy
    if (eng_phase != IDLE_PH) it.opcode = 3'($urandom_range(OP_UNKNOWN_HI, OP_NONE));
    else if (pick < 80) it.opcode = 3'($urandom_range(OP_READ, OP_START));
    else if (pick < 90) it.opcode = OP_NONE;
    else it.opcode = 3'($urandom_range(OP_UNKNOWN_HI, OP_UNKNOWN_LO));
    return it;
  endfunction

  task automatic run_random_phase(input int sidle, input int ridle, input logic [15:0] ticks);
    in_item_t it;
    int       counted;
    drain_results();
    write_wait_ticks(ticks);
    send_idle = sidle;
    recv_idle = ridle;
    counted = 0;
    while (counted < ITEMS_PER_PHASE) begin
      if ($urandom_range(149) == 0) drain_results();
      it = random_tick();
      if (eng_phase != IDLE_PH || (it.opcode >= OP_START && it.opcode <= OP_READ))
        counted++;
      send_tick(it, 1'b0, '0);
    end
  endtask

  initial begin
    in_item_t it;
    int       i;
    // stim, typed, want {scl, sda, busy, done, rx, ack}, drain, set wait, wait value
    script[0]  = '{'{OP_NONE, 8'h00, 1'b0, 1'b1, 1'b1}, 1'b1,
                   '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0}, 1'b0, 1'b0, 16'd0};
    script[1]  = '{'{OP_START, 8'h00, 1'b0, 1'b1, 1'b1}, 1'b1,
                   '{1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0}, 1'b1, 1'b1, 16'd0};
    script[2]  = '{'{OP_WRITE, 8'hFF, 1'b0, 1'b1, 1'b1}, 1'b1,
                   '{1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0}, 1'b1, 1'b0, 16'd0};
    script[3]  = '{'{OP_WRITE, 8'h00, 1'b0, 1'b0, 1'b1}, 1'b1,
                   '{1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b1}, 1'b1, 1'b0, 16'd0};
    script[4]  = '{'{OP_READ, 8'h00, 1'b1, 1'b1, 1'b1}, 1'b0, '0, 1'b1, 1'b0, 16'd0};
    script[5]  = '{'{OP_READ, 8'hFF, 1'b0, 1'b0, 1'b1}, 1'b0, '0, 1'b1, 1'b0, 16'd0};
    // stop, then hold scl low on the release to stretch the clock
    script[6]  = '{'{OP_STOP, 8'h00, 1'b0, 1'b1, 1'b1}, 1'b0, '0, 1'b0, 1'b0, 16'd0};
    script[7]  = '{'{OP_NONE, 8'h00, 1'b0, 1'b1, 1'b1}, 1'b0, '0, 1'b0, 1'b0, 16'd0};
    script[8]  = '{'{OP_NONE, 8'h00, 1'b0, 1'b1, 1'b0}, 1'b0, '0, 1'b0, 1'b0, 16'd0};
    script[9]  = '{'{OP_NONE, 8'h00, 1'b0, 1'b1, 1'b0}, 1'b0, '0, 1'b0, 1'b0, 16'd0};
    script[10] = '{'{OP_NONE, 8'h00, 1'b0, 1'b1, 1'b1}, 1'b0, '0, 1'b1, 1'b0, 16'd0};
    // unknown opcodes leave the engine idle
    script[11] = '{'{OP_UNKNOWN_LO, 8'h00, 1'b0, 1'b1, 1'b1}, 1'b1,
                   '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0}, 1'b0, 1'b0, 16'd0};
    script[12] = '{'{OP_UNKNOWN_HI, 8'hFF, 1'b1, 1'b0, 1'b0}, 1'b1,
                   '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0}, 1'b0, 1'b0, 16'd0};
    script[13] = '{'{OP_READ + 3'd2, 8'h5A, 1'b1, 1'b1, 1'b1}, 1'b0, '0, 1'b0, 1'b0, 16'd0};
    // a start, then commands sent while busy are dropped
    script[14] = '{'{OP_START, 8'h00, 1'b0, 1'b1, 1'b1}, 1'b0, '0, 1'b0, 1'b0, 16'd0};
    script[15] = '{'{OP_WRITE, 8'hA5, 1'b0, 1'b0, 1'b1}, 1'b0, '0, 1'b0, 1'b0, 16'd0};
    script[16] = '{'{OP_READ, 8'h3C, 1'b1, 1'b0, 1'b1}, 1'b0, '0, 1'b1, 1'b0, 16'd0};

    in_if.valid = 1'b0;
    in_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    out_if.ready = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (i = 0; i < SCRIPT_LEN; i++) begin
      send_tick(script[i].stim, script[i].typed, script[i].want);
      if (script[i].drain) begin
        it = script[i].stim;
        it.opcode = OP_NONE;
        while (eng_phase != IDLE_PH) send_tick(it, 1'b0, '0);
      end
      if (script[i].set_wait) begin
        drain_results();
        write_wait_ticks(script[i].wait_val);
      end
    end

    run_random_phase(14, 81, 16'd1);
    run_random_phase(81, 14, 16'($urandom_range(4, 2)));
    run_random_phase(0, 0, 16'd0);

    // longest wait: the countdown starts from the top of the range
    drain_results();
    write_wait_ticks(16'hFFFF);
    it = random_tick();
    it.opcode = OP_START;
    send_tick(it, 1'b0, '0);
    repeat (LONG_WAIT_TICKS) send_tick(random_tick(), 1'b0, '0);

    drain_results();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[i2c_master_byte_engine.f]
src/i2cm_pkg.sv
src/i2cm_if.sv
src/i2c_master_byte_engine.sv
dv/i2c_master_byte_engine_tb.sv
